>>> src/sfr_pkg.sv
// Shared types, constants and CRC helper for the signature frame receiver.
package sfr_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int WIN_BYTES   = 4;
    localparam int CRC_POS     = 4;
    localparam int PAY_POS     = 8;
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);

    localparam logic [31:0] SIG_RESET = 32'h454B_4F47;
    localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    typedef logic [7:0]        byte_t;
    typedef logic [FILL_W-1:0] fill_t;

    // One complete frame handed from the front end to the CRC checker.
    typedef struct packed {
        logic [31:0] payload;   // byte 8 in bits 7:0, byte 11 in bits 31:24
        logic [31:0] crc_rx;    // received CRC, little-endian
    } job_t;

    // CRC-32/MPEG-2 update by one byte, MSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input byte_t data);
        logic [31:0] c;
        c = crc_in ^ {data, 24'h000000};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> src/sfr_front.sv
// Front end: signature hunt over a sliding window and frame collection.
module sfr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                push_valid,
    input  logic                push_ready,
    output sfr_pkg::job_t       push_job
);
    import sfr_pkg::*;

    logic [31:0] sig_reg;
    byte_t       store_reg [STORE_DEPTH];
    fill_t       fill_reg, fill_next;
    logic        synced_reg, synced_next;

    logic        accept;
    fill_t       idx;
    logic [31:0] window_word;
    logic        last_byte;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // Recover a sane write position if the fill count is ever out of range.
    assign idx = (fill_reg < fill_t'(WIN_BYTES) || fill_reg >= fill_t'(FRAME_BYTES))
                 ? fill_t'(WIN_BYTES) : fill_reg;
    assign last_byte   = (idx == fill_t'(FRAME_BYTES - 1));
    assign window_word = {s_rx_byte, store_reg[3], store_reg[2], store_reg[1]};

    assign push_valid       = accept && synced_reg && last_byte;
    assign push_job.payload = {s_rx_byte, store_reg[PAY_POS+2], store_reg[PAY_POS+1],
                               store_reg[PAY_POS]};
    assign push_job.crc_rx  = {store_reg[CRC_POS+3], store_reg[CRC_POS+2],
                               store_reg[CRC_POS+1], store_reg[CRC_POS]};

    always_comb begin
        fill_next   = fill_reg;
        synced_next = synced_reg;
        if (accept) begin
            if (!synced_reg) begin
                if (fill_reg < fill_t'(WIN_BYTES)) begin
                    fill_next = fill_reg + fill_t'(1);
                end
                if (fill_reg >= fill_t'(WIN_BYTES - 1) && window_word == sig_reg) begin
                    synced_next = 1'b1;
                    fill_next   = fill_t'(WIN_BYTES);
                end
            end else if (last_byte) begin
                synced_next = 1'b0;
                fill_next   = '0;
            end else begin
                fill_next = idx + fill_t'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_reg    <= SIG_RESET;
            fill_reg   <= '0;
            synced_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                sig_reg <= cfg_wdata;
            end
            fill_reg   <= fill_next;
            synced_reg <= synced_next;
        end
    end

    // Window shifts while hunting; body bytes land at the fill position.
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (!synced_reg) begin
                for (int i = 0; i < WIN_BYTES - 1; i++) begin
                    store_reg[i] <= store_reg[i+1];
                end
                store_reg[WIN_BYTES-1] <= s_rx_byte;
            end else if (!last_byte) begin
                store_reg[idx] <= s_rx_byte;
            end
        end
    end

endmodule

>>> src/sfr_queue.sv
// Two-entry queue of completed frames between front end and CRC checker.
module sfr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  sfr_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output sfr_pkg::job_t pop_job
);
    import sfr_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> src/sfr_back.sv
// Back end: byte-serial CRC-32/MPEG-2 check and result output register.
module sfr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  sfr_pkg::job_t pop_job,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_msg_code,
    output logic [7:0]    m_status_code,
    output logic [7:0]    m_reserved_first,
    output logic [7:0]    m_reserved_second,
    output logic          m_crc_error
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_HOLD
    } state_t;

    state_t      state_reg;
    logic [31:0] payload_reg;
    logic [31:0] shift_reg;
    logic [31:0] crc_rx_reg;
    logic [31:0] crc_reg;
    logic [1:0]  step_reg;
    logic [31:0] crc_next;

    assign pop_ready = (state_reg == ST_IDLE);
    assign crc_next  = crc_byte(crc_reg, shift_reg[31:24]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
            step_reg  <= 2'd0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        payload_reg <= pop_job.payload;
                        shift_reg   <= pop_job.payload;
                        crc_rx_reg  <= pop_job.crc_rx;
                        crc_reg     <= CRC_INIT;
                        step_reg    <= 2'd0;
                        state_reg   <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    // Feed the payload word high byte first.
                    crc_reg   <= crc_next;
                    shift_reg <= {shift_reg[23:0], 8'h00};
                    step_reg  <= step_reg + 2'd1;
                    if (step_reg == 2'd3) begin
                        m_msg_code        <= payload_reg[7:0];
                        m_status_code     <= payload_reg[15:8];
                        m_reserved_first  <= payload_reg[23:16];
                        m_reserved_second <= payload_reg[31:24];
                        m_crc_error       <= (crc_next != crc_rx_reg);
                        m_valid           <= 1'b1;
                        state_reg         <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/signature_frame_receiver_crc32_core.sv
// Top level of the signature-framed receiver with CRC-32/MPEG-2 check.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_rx_byte (one received byte)
//  m_        out        m_valid/m_ready    msg, status, two reserved bytes, crc_error
//  cfg_      in         cfg_we             cfg_wdata (frame signature)
//
// The front end takes one byte per cycle; s_ready drops only while the two-entry
// frame queue is full. The checker loads each frame, runs four CRC byte steps
// and holds the result until m_ready; bytes stream at one per cycle unless an
// m_ready stall fills the queue. Reset (aresetn, synchronous) restores the
// signature register and starts hunting with an empty window.
module signature_frame_receiver_crc32_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_msg_code,
    output logic [7:0]  m_status_code,
    output logic [7:0]  m_reserved_first,
    output logic [7:0]  m_reserved_second,
    output logic        m_crc_error
);
    import sfr_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    job_t push_job, pop_job;

    sfr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    sfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    sfr_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_job           (pop_job),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_msg_code        (m_msg_code),
        .m_status_code     (m_status_code),
        .m_reserved_first  (m_reserved_first),
        .m_reserved_second (m_reserved_second),
        .m_crc_error       (m_crc_error)
    );

endmodule
